/* rtl/core/cctc_pkg.sv */
// ----------------------------------------------------------------------------
// cctc_pkg
// Shared types, codes and calendar helpers for the calendar clock unit.
// ----------------------------------------------------------------------------
package cctc_pkg;

  // Request kinds carried on the input tuser
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_CMP  = 2'd2;

  // Compare result codes
  localparam logic [1:0] ORD_LESS = 2'd0;
  localparam logic [1:0] ORD_EQ   = 2'd1;
  localparam logic [1:0] ORD_MORE = 2'd2;

  // Field widths
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned TdataW = 48;

  // Divisibility by 25: multiply by the inverse of 25 mod 2^16, then a
  // multiple of 25 maps to at most (2^16 - 1) / 25
  localparam logic [YearW-1:0] Inv25 = 16'd23593;
  localparam logic [YearW-1:0] Max25 = 16'd2621;

  // Control into one cell
  typedef struct packed {
    logic load;
  } cell_ctrl_t;

  // Data handed from one cell to the next more significant cell
  typedef struct packed {
    logic       carry;
    logic [1:0] ord;
  } cell_link_t;

  // Gregorian rule: div by 4 and not by 100, or div by 400
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * Inv25;
    div25 = (prod <= Max25);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  // Length of a month; codes outside 1..12 fall back to the long month
  function automatic logic [DayW-1:0] days_in_month(input logic [MonW-1:0] m,
                                                    input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/core/cctc_cell.sv */
// ----------------------------------------------------------------------------
// cctc_cell
// One calendar field: holds its count, advances or wraps on carry, takes a load,
// and passes carry and compare order up to the next field.
// ----------------------------------------------------------------------------
module cctc_cell
  import cctc_pkg::*;
#(
  parameter int unsigned      WIDTH     = 6,
  parameter logic [WIDTH-1:0] RST_VAL   = '0,
  parameter logic [WIDTH-1:0] FIRST_VAL = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctrl_t       ctrl,
  input  logic [WIDTH-1:0] din,
  input  logic [WIDTH-1:0] last_val,
  input  cell_link_t       link_in,
  output cell_link_t       link_out,
  output logic [WIDTH-1:0] count,
  output logic [WIDTH-1:0] count_nxt
);

  logic [WIDTH-1:0] count_r;
  logic             at_last;

  assign at_last = (count_r == last_val);

  // Advance or wrap on carry, overwrite on load
  always_comb begin
    priority if (ctrl.load) begin
      count_nxt = din;
    end else if (link_in.carry) begin
      count_nxt = at_last ? FIRST_VAL : count_r + 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  // Pass carry up; a differing field overrides the lower-field order
  always_comb begin
    link_out.carry = link_in.carry && at_last;
    if (count_r > din) begin
      link_out.ord = ORD_MORE;
    end else if (count_r < din) begin
      link_out.ord = ORD_LESS;
    end else begin
      link_out.ord = link_in.ord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= RST_VAL;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;

endmodule

/* rtl/core/calendar_clock_tick_compare_unit.sv */
// ----------------------------------------------------------------------------
// calendar_clock_tick_compare_unit
// Calendar clock (second to year) with tick, load and compare requests.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while in_tready is high and returns
// one result per request, in the cycle after it is accepted, in order. The
// six calendar fields sit in a row of cells from second to year; the tick
// carry and the compare order ripple combinationally through that row and
// every cell updates at the clock edge, so the clock period is set by that
// six-cell cascade plus the day-limit lookup. A single output register holds
// the result; while it waits for out_tready a new request is still taken as
// long as the result is consumed in the same cycle. A load with any field out
// of range is refused, flagged by load_error, and leaves the time unchanged.
// After reset the time is 1 January 1970, 00:00:00.
// ----------------------------------------------------------------------------
module calendar_clock_tick_compare_unit
  import cctc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [5:0] in_second, [11:6] in_minute, [16:12] in_hour, [21:17] in_day,
  // [25:22] in_month, [41:26] in_year, [47:42] zero
  input  logic [TdataW-1:0] in_tdata,
  // [1:0] op
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [5:0] cur_second, [11:6] cur_minute, [16:12] cur_hour, [21:17] cur_day,
  // [25:22] cur_month, [41:26] cur_year, [43:42] order, [44] load_error,
  // [45] leap_year, [47:46] zero
  output logic [TdataW-1:0] out_tdata
);

  logic [SecW-1:0]  in_second;
  logic [MinW-1:0]  in_minute;
  logic [HourW-1:0] in_hour;
  logic [DayW-1:0]  in_day;
  logic [MonW-1:0]  in_month;
  logic [YearW-1:0] in_year;

  assign in_second = in_tdata[5:0];
  assign in_minute = in_tdata[11:6];
  assign in_hour   = in_tdata[16:12];
  assign in_day    = in_tdata[21:17];
  assign in_month  = in_tdata[25:22];
  assign in_year   = in_tdata[41:26];

  logic in_fire;
  logic out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Current field values and their next values
  logic [SecW-1:0]  sec_q,  sec_nxt;
  logic [MinW-1:0]  min_q,  min_nxt;
  logic [HourW-1:0] hour_q, hour_nxt;
  logic [DayW-1:0]  day_q,  day_nxt;
  logic [MonW-1:0]  mon_q,  mon_nxt;
  logic [YearW-1:0] year_q, year_nxt;

  // Validate a load against the month length of the loaded year
  logic            load_ok;
  logic [DayW-1:0] load_dim;

  assign load_dim = days_in_month(in_month, is_leap(in_year));
  assign load_ok  = (in_second < 6'd60) && (in_minute < 6'd60) &&
                    (in_hour < 5'd24) && (in_month >= 4'd1) &&
                    (in_month <= 4'd12) && (in_day >= 5'd1) &&
                    (in_day <= load_dim);

  logic       is_tick, is_load, is_cmp;
  cell_ctrl_t ctrl;

  assign is_tick   = (in_tuser == OP_TICK);
  assign is_load   = (in_tuser == OP_LOAD);
  assign is_cmp    = (in_tuser == OP_CMP);
  assign ctrl.load = in_fire && is_load && load_ok;

  // Day limit of the stored month
  logic [DayW-1:0] cur_dim;
  assign cur_dim = days_in_month(mon_q, is_leap(year_q));

  // Links between cells, second first
  cell_link_t link_sec_in, link_sec, link_min, link_hour, link_day, link_mon;
  cell_link_t link_year;

  assign link_sec_in.carry = in_fire && is_tick;
  assign link_sec_in.ord   = ORD_EQ;

  cctc_cell #(.WIDTH(SecW), .RST_VAL(6'd0), .FIRST_VAL(6'd0)) u_sec (
    .clk, .rst_n, .ctrl, .din(in_second), .last_val(6'd59),
    .link_in(link_sec_in), .link_out(link_sec), .count(sec_q), .count_nxt(sec_nxt)
  );

  cctc_cell #(.WIDTH(MinW), .RST_VAL(6'd0), .FIRST_VAL(6'd0)) u_min (
    .clk, .rst_n, .ctrl, .din(in_minute), .last_val(6'd59),
    .link_in(link_sec), .link_out(link_min), .count(min_q), .count_nxt(min_nxt)
  );

  cctc_cell #(.WIDTH(HourW), .RST_VAL(5'd0), .FIRST_VAL(5'd0)) u_hour (
    .clk, .rst_n, .ctrl, .din(in_hour), .last_val(5'd23),
    .link_in(link_min), .link_out(link_hour), .count(hour_q), .count_nxt(hour_nxt)
  );

  cctc_cell #(.WIDTH(DayW), .RST_VAL(5'd1), .FIRST_VAL(5'd1)) u_day (
    .clk, .rst_n, .ctrl, .din(in_day), .last_val(cur_dim),
    .link_in(link_hour), .link_out(link_day), .count(day_q), .count_nxt(day_nxt)
  );

  cctc_cell #(.WIDTH(MonW), .RST_VAL(4'd1), .FIRST_VAL(4'd1)) u_mon (
    .clk, .rst_n, .ctrl, .din(in_month), .last_val(4'd12),
    .link_in(link_day), .link_out(link_mon), .count(mon_q), .count_nxt(mon_nxt)
  );

  cctc_cell #(.WIDTH(YearW), .RST_VAL(16'd1970), .FIRST_VAL(16'd0)) u_year (
    .clk, .rst_n, .ctrl, .din(in_year), .last_val(16'hFFFF),
    .link_in(link_mon), .link_out(link_year), .count(year_q), .count_nxt(year_nxt)
  );

  // Result register
  logic [SecW-1:0]  out_sec_r;
  logic [MinW-1:0]  out_min_r;
  logic [HourW-1:0] out_hour_r;
  logic [DayW-1:0]  out_day_r;
  logic [MonW-1:0]  out_mon_r;
  logic [YearW-1:0] out_year_r;
  logic [1:0]       out_ord_r;
  logic             out_err_r;
  logic             out_valid_nxt;

  always_comb begin
    priority if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the time after this request plus its flags
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_sec_r  <= sec_nxt;
      out_min_r  <= min_nxt;
      out_hour_r <= hour_nxt;
      out_day_r  <= day_nxt;
      out_mon_r  <= mon_nxt;
      out_year_r <= year_nxt;
      out_ord_r  <= is_cmp ? link_year.ord : ORD_EQ;
      out_err_r  <= is_load && !load_ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, is_leap(out_year_r), out_err_r, out_ord_r, out_year_r,
                       out_mon_r, out_day_r, out_hour_r, out_min_r, out_sec_r};

endmodule

/* rtl/core/cctc_checker.sv */
// ----------------------------------------------------------------------------
// cctc_checker
// Port-level checks for the calendar clock unit, bound to the top level.
// ----------------------------------------------------------------------------
module cctc_checker
  import cctc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [TdataW-1:0] out_tdata
);

  // No result pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Every accepted request shows a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted request gave no result");

  // An empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Order code is always a defined compare result
  a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[43:42] == ORD_LESS || out_tdata[43:42] == ORD_EQ ||
                    out_tdata[43:42] == ORD_MORE))
    else $error("undefined order code");

endmodule

bind calendar_clock_tick_compare_unit cctc_checker u_cctc_checker (.*);
